### rtl/ppp_pkg.sv
// Shared types and constants of the perspective point projector.
`default_nettype none
package ppp_pkg;

  localparam int unsigned MatrixEntries = 16;
  localparam int unsigned FractionBitsDefault = 16;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DimWidth = 14;
  localparam int unsigned IndexWidth = $clog2(MatrixEntries);

  localparam logic [DimWidth-1:0] WidthReset = DimWidth'(1920);
  localparam logic [DimWidth-1:0] HeightReset = DimWidth'(1080);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    op_e                          op;
    logic [IndexWidth-1:0]        index;
    logic signed [CoordWidth-1:0] value;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

endpackage
`default_nettype wire

### rtl/ppp_front.sv
// Front end: accepts items, decodes the command and queues them in a two-entry queue.
`default_nettype none
module ppp_front
  import ppp_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [IndexWidth-1:0]        entry_index_i,
  input  wire logic signed [CoordWidth-1:0] entry_value_i,
  input  wire logic signed [CoordWidth-1:0] world_x_i,
  input  wire logic signed [CoordWidth-1:0] world_y_i,
  input  wire logic signed [CoordWidth-1:0] world_z_i,
  input  wire logic                         pop_i,
  output queue_ctl_t                        ctl_o,
  output item_t                             item_o
);

  item_t       slot_q [2];
  logic        rd_ptr_q, wr_ptr_q;
  logic [1:0]  count_q;
  logic        push;
  logic        pop;
  item_t       in_item;

  always_comb begin
    in_item.op    = cmd_i ? OP_PROJECT : OP_LOAD;
    in_item.index = entry_index_i;
    in_item.value = entry_value_i;
    in_item.x     = world_x_i;
    in_item.y     = world_y_i;
    in_item.z     = world_z_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign ctl_o.valid = (count_q != 2'd0);
  assign ctl_o.pop   = pop;
  assign item_o      = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/ppp_xform.sv
// Matrix store and transform stages: products, clip sums, fallback select and range test.
`default_nettype none
module ppp_xform
  import ppp_pkg::*;
#(
  parameter int unsigned FractionBits = FractionBitsDefault,
  localparam int unsigned SumWidth = 2 * CoordWidth - FractionBits + 3,
  localparam int unsigned DivWidth = SumWidth + 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire queue_ctl_t          ctl_i,
  input  wire item_t               item_i,
  output logic                     valid_o,
  output logic                     on_o,
  output logic [DivWidth-1:0]      num_x_o,
  output logic [DivWidth-1:0]      num_y_o,
  output logic [DivWidth-1:0]      den_o
);

  localparam int unsigned ProdWidth = 2 * CoordWidth;
  localparam logic signed [SumWidth-1:0] WMin =
    SumWidth'(((64'd1 << FractionBits) + 64'd9999) / 64'd10000);

  logic signed [CoordWidth-1:0] mat_q [MatrixEntries];

  // product order: row x, row y, row w, then col x, col y, col w; three terms each
  logic signed [ProdWidth-1:0] prod_q [18];
  logic signed [CoordWidth-1:0] offs_q [6];
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  logic signed [SumWidth-1:0] sum_q [6];

  logic on_q;
  logic [DivWidth-1:0] num_x_q, num_y_q, den_q;

  logic take;
  logic load;

  function automatic logic signed [SumWidth-1:0] floor_shift(
    input logic signed [ProdWidth-1:0] p
  );
    logic signed [ProdWidth-1:0] s;
    s = p >>> FractionBits;
    return s[SumWidth-1:0];
  endfunction

  function automatic logic signed [SumWidth-1:0] ext(
    input logic signed [CoordWidth-1:0] v
  );
    return SumWidth'(v);
  endfunction

  assign take = en_i && ctl_i.valid && ctl_i.pop;
  assign load = take && (item_i.op == OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MatrixEntries; i++) mat_q[i] <= '0;
    end else if (load) begin
      mat_q[item_i.index] <= item_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= take && (item_i.op == OP_PROJECT);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Products: one 32x32 multiply per term, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0]  <= item_i.x * mat_q[0];
      prod_q[1]  <= item_i.y * mat_q[1];
      prod_q[2]  <= item_i.z * mat_q[2];
      prod_q[3]  <= item_i.x * mat_q[4];
      prod_q[4]  <= item_i.y * mat_q[5];
      prod_q[5]  <= item_i.z * mat_q[6];
      prod_q[6]  <= item_i.x * mat_q[12];
      prod_q[7]  <= item_i.y * mat_q[13];
      prod_q[8]  <= item_i.z * mat_q[14];
      prod_q[9]  <= item_i.x * mat_q[0];
      prod_q[10] <= item_i.y * mat_q[4];
      prod_q[11] <= item_i.z * mat_q[8];
      prod_q[12] <= item_i.x * mat_q[1];
      prod_q[13] <= item_i.y * mat_q[5];
      prod_q[14] <= item_i.z * mat_q[9];
      prod_q[15] <= item_i.x * mat_q[3];
      prod_q[16] <= item_i.y * mat_q[7];
      prod_q[17] <= item_i.z * mat_q[11];
      offs_q[0]  <= mat_q[3];
      offs_q[1]  <= mat_q[7];
      offs_q[2]  <= mat_q[15];
      offs_q[3]  <= mat_q[12];
      offs_q[4]  <= mat_q[13];
      offs_q[5]  <= mat_q[15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        sum_q[k] <= floor_shift(prod_q[3*k]) + floor_shift(prod_q[3*k+1])
                  + floor_shift(prod_q[3*k+2]) + ext(offs_q[k]);
      end
    end
  end

  // Fall back to the transposed sums when the row-major w is too small.
  logic signed [SumWidth-1:0] cx, cy, cw;
  logic in_range;
  always_comb begin
    if (sum_q[2] < WMin) begin
      cx = sum_q[3];
      cy = sum_q[4];
      cw = sum_q[5];
    end else begin
      cx = sum_q[0];
      cy = sum_q[1];
      cw = sum_q[2];
    end
    in_range = (cw >= WMin) && (cx >= -cw) && (cx <= cw) && (cy >= -cw) && (cy <= cw);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      on_q <= in_range;
      if (in_range) begin
        num_x_q <= DivWidth'(cw) + DivWidth'(cx);
        num_y_q <= DivWidth'(cw) - DivWidth'(cy);
        den_q   <= DivWidth'(cw) << 1;
      end else begin
        num_x_q <= '0;
        num_y_q <= '0;
        den_q   <= DivWidth'(1);
      end
    end
  end

  assign valid_o = s3_valid_q;
  assign on_o    = on_q;
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign den_o   = den_q;

endmodule
`default_nettype wire

### rtl/ppp_div.sv
// Pixel mapping: pipelined scaled ratio, one scale bit per stage, for both axes.
`default_nettype none
module ppp_div
  import ppp_pkg::*;
#(
  parameter int unsigned DivWidth = 2 * CoordWidth - FractionBitsDefault + 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic                on_i,
  input  wire logic [DivWidth-1:0] num_x_i,
  input  wire logic [DivWidth-1:0] num_y_i,
  input  wire logic [DivWidth-1:0] den_i,
  input  wire logic [DimWidth-1:0] width_i,
  input  wire logic [DimWidth-1:0] height_i,
  output logic                     valid_o,
  output logic                     on_o,
  output logic [DimWidth-1:0]      x_o,
  output logic [DimWidth-1:0]      y_o
);

  localparam int unsigned Stages = DimWidth;
  localparam int unsigned RemWidth = DivWidth + 2;

  logic                valid_q [Stages];
  logic                on_q    [Stages];
  logic [DivWidth-1:0] nx_q    [Stages];
  logic [DivWidth-1:0] ny_q    [Stages];
  logic [DivWidth-1:0] den_q   [Stages];
  logic [RemWidth-1:0] rx_q    [Stages];
  logic [RemWidth-1:0] ry_q    [Stages];
  logic [DimWidth-1:0] qx_q    [Stages];
  logic [DimWidth-1:0] qy_q    [Stages];

  typedef struct packed {
    logic [RemWidth-1:0] r;
    logic [DimWidth-1:0] q;
  } step_t;

  // Double the remainder, add num on a set scale bit, subtract den once or twice.
  function automatic step_t ratio_step(
    input logic [RemWidth-1:0] r,
    input logic [DimWidth-1:0] q,
    input logic                bit_set,
    input logic [DivWidth-1:0] num,
    input logic [DivWidth-1:0] den
  );
    step_t res;
    logic [RemWidth-1:0] t, d1, d2;
    t  = (r << 1) + (bit_set ? RemWidth'(num) : '0);
    d1 = RemWidth'(den);
    d2 = RemWidth'(den) << 1;
    if (t >= d2) begin
      res.r = t - d2;
      res.q = (q << 1) + DimWidth'(2);
    end else if (t >= d1) begin
      res.r = t - d1;
      res.q = (q << 1) + DimWidth'(1);
    end else begin
      res.r = t;
      res.q = q << 1;
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < Stages; s++) valid_q[s] <= valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    step_t sx, sy;
    if (en_i) begin
      sx = ratio_step('0, '0, width_i[Stages-1], num_x_i, den_i);
      sy = ratio_step('0, '0, height_i[Stages-1], num_y_i, den_i);
      on_q[0]  <= on_i;
      nx_q[0]  <= num_x_i;
      ny_q[0]  <= num_y_i;
      den_q[0] <= den_i;
      rx_q[0]  <= sx.r;
      qx_q[0]  <= sx.q;
      ry_q[0]  <= sy.r;
      qy_q[0]  <= sy.q;
      for (int s = 1; s < Stages; s++) begin
        sx = ratio_step(rx_q[s-1], qx_q[s-1], width_i[Stages-1-s], nx_q[s-1], den_q[s-1]);
        sy = ratio_step(ry_q[s-1], qy_q[s-1], height_i[Stages-1-s], ny_q[s-1], den_q[s-1]);
        on_q[s]  <= on_q[s-1];
        nx_q[s]  <= nx_q[s-1];
        ny_q[s]  <= ny_q[s-1];
        den_q[s] <= den_q[s-1];
        rx_q[s]  <= sx.r;
        qx_q[s]  <= sx.q;
        ry_q[s]  <= sy.r;
        qy_q[s]  <= sy.q;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign on_o    = on_q[Stages-1];
  assign x_o     = qx_q[Stages-1];
  assign y_o     = qy_q[Stages-1];

endmodule
`default_nettype wire

### rtl/perspective_point_projector.sv
// Top level of the perspective point projector: configuration registers and pipeline glue.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per handshake. cmd_i = 0 loads
//   entry_value_i into matrix entry entry_index_i and yields no result; cmd_i = 1 projects
//   the Q16.16 point world_x_i/y_i/z_i and yields exactly one result item.
//   Output channel (out_valid_o/out_ready_i) carries on_screen_o, screen_x_o, screen_y_o;
//   off-screen results show zero pixels.
//   APB port: register 0 at address 0 is screen_width, register 1 at address 4 is
//   screen_height. Write them only while no point is in flight.
// Throughput: one item per cycle while the output is not stalled. The front end queues
//   up to two items; the back end advances all stages together on one enable.
// Pipeline: a point enters the queue at the accepting edge, then passes three transform
//   stages (multiply, clip sums, select and range test) and fourteen pixel-mapping stages,
//   one per bit of the viewport size, before out_valid_o rises.
// Reset: clears the matrix to zero, empties the queue and pipeline, and loads 1920x1080.
// Stall: while out_valid_o is high and out_ready_i low, hold every back-end stage; the
//   queue still accepts up to two items, then in_ready_o drops.
`default_nettype none
module perspective_point_projector
  import ppp_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FractionBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [IndexWidth-1:0]        entry_index_i,
  input  wire logic signed [CoordWidth-1:0] entry_value_i,
  input  wire logic signed [CoordWidth-1:0] world_x_i,
  input  wire logic signed [CoordWidth-1:0] world_y_i,
  input  wire logic signed [CoordWidth-1:0] world_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              on_screen_o,
  output logic [DimWidth-1:0]               screen_x_o,
  output logic [DimWidth-1:0]               screen_y_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned DivWidth = 2 * CoordWidth - FRACTION_BITS + 5;

  logic [DimWidth-1:0] width_q, height_q;
  logic                en;
  queue_ctl_t          qctl;
  item_t               qitem;
  logic                xf_valid, xf_on;
  logic [DivWidth-1:0] num_x, num_y, den;
  reg_e                reg_sel;

  // Configuration registers; the low address bits select nothing.
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[DimWidth-1:0];
        REG_HEIGHT: height_q <= pwdata[DimWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Advance the back end unless a finished result waits at the output.
  assign en = !out_valid_o || out_ready_i;

  ppp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .entry_index_i,
    .entry_value_i,
    .world_x_i,
    .world_y_i,
    .world_z_i,
    .pop_i  (en),
    .ctl_o  (qctl),
    .item_o (qitem)
  );

  ppp_xform #(
    .FractionBits (FRACTION_BITS)
  ) u_xform (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .ctl_i   (qctl),
    .item_i  (qitem),
    .valid_o (xf_valid),
    .on_o    (xf_on),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den)
  );

  ppp_div #(
    .DivWidth (DivWidth)
  ) u_div (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .valid_i  (xf_valid),
    .on_i     (xf_on),
    .num_x_i  (num_x),
    .num_y_i  (num_y),
    .den_i    (den),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (out_valid_o),
    .on_o     (on_screen_o),
    .x_o      (screen_x_o),
    .y_o      (screen_y_o)
  );

endmodule
`default_nettype wire

### rtl/ppp_checker.sv
// Port-level checks of the perspective point projector, bound to the top level.
`default_nettype none
module ppp_checker
  import ppp_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                on_screen_o,
  input wire logic [DimWidth-1:0] screen_x_o,
  input wire logic [DimWidth-1:0] screen_y_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_offscreen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !on_screen_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("off-screen result with nonzero pixels");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(on_screen_o) && $stable(screen_x_o) && $stable(screen_y_o)))
    else $error("result changed while stalled");

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .on_screen_o,
  .screen_x_o,
  .screen_y_o
);
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the perspective point projector.
`timescale 1ns / 100ps
module testbench;
  import ppp_pkg::*;

  localparam int Frac = FractionBitsDefault;
  localparam int One = 1 << Frac;
  // w threshold 0.0001 in Q16.16, rounded up
  localparam longint WMin = ((longint'(1) << Frac) + 9999) / 10000;

  typedef struct {
    logic                on;
    logic [DimWidth-1:0] px;
    logic [DimWidth-1:0] py;
  } pixel_t;

  typedef struct {
    op_e                          op;
    logic [IndexWidth-1:0]        idx;
    logic signed [CoordWidth-1:0] val;
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic signed [CoordWidth-1:0] z;
    bit                           typed;
    pixel_t                       want;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  op_e                          cmd = OP_LOAD;
  logic [IndexWidth-1:0]        entry_index = '0;
  logic signed [CoordWidth-1:0] entry_value = '0;
  logic signed [CoordWidth-1:0] world_x = '0;
  logic signed [CoordWidth-1:0] world_y = '0;
  logic signed [CoordWidth-1:0] world_z = '0;
  // expectation typed into the directed table, travels with the item
  bit                           item_typed = 1'b0;
  pixel_t                       item_want = '{1'b0, '0, '0};

  // output channel
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                on_screen;
  logic [DimWidth-1:0] screen_x;
  logic [DimWidth-1:0] screen_y;

  // APB
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow state of the block
  logic signed [CoordWidth-1:0] shadow_matrix [MatrixEntries];
  logic [DimWidth-1:0]          view_w;
  logic [DimWidth-1:0]          view_h;

  pixel_t pending_pixels[$];
  row_t   directed_rows[$];
  int     errors = 0;
  bit     send_idle = 1'b1;
  bit     recv_idle = 1'b1;
  int     recv_hold = 0;

  perspective_point_projector DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .entry_index_i(entry_index),
    .entry_value_i(entry_value),
    .world_x_i    (world_x),
    .world_y_i    (world_y),
    .world_z_i    (world_z),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .on_screen_o  (on_screen),
    .screen_x_o   (screen_x),
    .screen_y_o   (screen_y),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Product of coordinate and entry, floored to the fixed-point grid.
  function automatic longint fixed_mul(logic signed [CoordWidth-1:0] a,
                                       logic signed [CoordWidth-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> Frac;
  endfunction

  function automatic longint clip_dot(logic signed [CoordWidth-1:0] x,
                                      logic signed [CoordWidth-1:0] y,
                                      logic signed [CoordWidth-1:0] z,
                                      int i0, int i1, int i2, int i3);
    return fixed_mul(x, shadow_matrix[i0]) + fixed_mul(y, shadow_matrix[i1])
         + fixed_mul(z, shadow_matrix[i2]) + longint'(shadow_matrix[i3]);
  endfunction

  // floor(scale * num / den), kept wide so nothing overflows
  function automatic logic [DimWidth-1:0] pixel_ratio(logic [DimWidth-1:0] scale,
                                                       longint num, longint den);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = 128'(scale) * 128'(num);
    quo  = prod / 128'(den);
    return quo[DimWidth-1:0];
  endfunction

  function automatic pixel_t project_point(logic signed [CoordWidth-1:0] x,
                                           logic signed [CoordWidth-1:0] y,
                                           logic signed [CoordWidth-1:0] z);
    longint cx, cy, cw;
    pixel_t r;
    r = '{1'b0, '0, '0};
    cx = clip_dot(x, y, z, 0, 1, 2, 3);
    cy = clip_dot(x, y, z, 4, 5, 6, 7);
    cw = clip_dot(x, y, z, 12, 13, 14, 15);
    // near-zero w: retry with the transposed matrix
    if (cw < WMin) begin
      cx = clip_dot(x, y, z, 0, 4, 8, 12);
      cy = clip_dot(x, y, z, 1, 5, 9, 13);
      cw = clip_dot(x, y, z, 3, 7, 11, 15);
    end
    if (cw < WMin) return r;
    if (cx < -cw || cx > cw || cy < -cw || cy > cw) return r;
    r.on = 1'b1;
    r.px = pixel_ratio(view_w, cw + cx, 2 * cw);
    r.py = pixel_ratio(view_h, cw - cy, 2 * cw);
    return r;
  endfunction

  // Track accepted items: update the shadow matrix, queue expected pixels.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MatrixEntries; i++) shadow_matrix[i] = '0;
    end else if (in_valid && in_ready) begin
      if (cmd == OP_LOAD) begin
        shadow_matrix[entry_index] = entry_value;
      end else if (item_typed) begin
        pending_pixels.push_back(item_want);
      end else begin
        pending_pixels.push_back(project_point(world_x, world_y, world_z));
      end
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: on=%0d x=%0d y=%0d",
                 $time, on_screen, screen_x, screen_y);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (on_screen !== e.on) begin
          $display("%0t: on_screen expected %0d actual %0d", $time, e.on, on_screen);
          errors++;
        end
        if (screen_x !== e.px) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, e.px, screen_x);
          errors++;
        end
        if (screen_y !== e.py) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, e.py, screen_y);
          errors++;
        end
      end
    end
  end

  // Receiver: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (!recv_idle) begin
      out_ready <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      recv_hold <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item, after an optional random gap, and hold it until accepted.
  task automatic send_item(op_e op, logic [IndexWidth-1:0] idx,
                           logic signed [CoordWidth-1:0] val,
                           logic signed [CoordWidth-1:0] x,
                           logic signed [CoordWidth-1:0] y,
                           logic signed [CoordWidth-1:0] z,
                           bit typed, pixel_t want);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    entry_index <= idx;
    entry_value <= val;
    world_x     <= x;
    world_y     <= y;
    world_z     <= z;
    item_typed  <= typed;
    item_want   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_load(int idx, logic signed [CoordWidth-1:0] val);
    send_item(OP_LOAD, idx[IndexWidth-1:0], val, $urandom, $urandom, $urandom,
              1'b0, '{1'b0, '0, '0});
  endtask

  task automatic send_point(logic signed [CoordWidth-1:0] x,
                            logic signed [CoordWidth-1:0] y,
                            logic signed [CoordWidth-1:0] z);
    send_item(OP_PROJECT, IndexWidth'($urandom), $urandom, x, y, z, 1'b0,
              '{1'b0, '0, '0});
  endtask

  // Drop valid, wait out every expected result, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic write_reg(reg_e r, logic [31:0] value);
    logic [DimWidth-1:0] kept;
    kept = value[DimWidth-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (r == REG_WIDTH) view_w = kept;
    else view_h = kept;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[DimWidth-1:0] !== kept) begin
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, r, kept, prdata[DimWidth-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CoordWidth-1:0] spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic void add_row(op_e op, int idx, int val, int x, int y, int z,
                                  bit typed, bit on, int px, int py);
    row_t r;
    r.op = op;
    r.idx = idx[IndexWidth-1:0];
    r.val = val;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want = '{on, px[DimWidth-1:0], py[DimWidth-1:0]};
    directed_rows.push_back(r);
  endfunction

  // Load a whole matrix of one random flavor.
  task automatic load_matrix(output int items);
    int flavor;
    logic signed [CoordWidth-1:0] m [MatrixEntries];
    flavor = $urandom_range(0, 3);
    for (int i = 0; i < MatrixEntries; i++) m[i] = spread(One / 4);
    case (flavor)
      0: begin
        // classic perspective: w follows z
        m[0]  = $urandom_range(One / 2, 2 * One);
        m[5]  = $urandom_range(One / 2, 2 * One);
        m[12] = 0;
        m[13] = 0;
        m[14] = One;
        m[15] = spread(One / 8);
      end
      1: begin
        // row w tiny: forces the transposed retry
        m[0]  = $urandom_range(One / 2, 2 * One);
        m[5]  = $urandom_range(One / 2, 2 * One);
        m[12] = 0;
        m[13] = 0;
        m[14] = 0;
        m[15] = $urandom_range(0, WMin - 1);
        m[11] = One;
      end
      2: begin
        for (int i = 0; i < MatrixEntries; i++) m[i] = spread(4 * One);
      end
      default: begin
        for (int i = 0; i < MatrixEntries; i++) m[i] = $urandom;
      end
    endcase
    for (int i = 0; i < MatrixEntries; i++) send_load(i, m[i]);
    items = MatrixEntries;
  endtask

  task automatic random_phase(int count);
    int sent;
    int n;
    int zz;
    int span;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        load_matrix(n);
        sent += n;
        repeat ($urandom_range(4, 16)) begin
          case ($urandom_range(0, 5))
            0: send_point($urandom, $urandom, $urandom);
            1: send_point(spread(One), spread(One), spread(One));
            default: begin
              zz = $urandom_range(One / 2, 8 * One);
              span = zz + zz / 4;
              send_point(spread(span), spread(span), zz);
            end
          endcase
          sent++;
        end
      end else begin
        // stray entry writes and wild points
        if ($urandom_range(0, 1) == 0) send_load($urandom_range(0, 15), $urandom);
        else send_point($urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    int cfg_w [6];
    int cfg_h [6];
    view_w = WidthReset;
    view_h = HeightReset;

    // after reset the matrix is zero: every point is off-screen
    add_row(OP_PROJECT, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, -1, 32'h7fffffff, 5, 1, 0, 0, 0);
    add_row(OP_LOAD, 0, One, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 5, One, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 15, One, 0, 0, 0, 0, 0, 0, 0);
    // identity with w = 1: center, edges and just past the edge
    add_row(OP_PROJECT, 0, 0, 0, 0, 0, 1, 1, 960, 540);
    add_row(OP_PROJECT, 0, 0, One, 0, 0, 1, 1, 1920, 540);
    add_row(OP_PROJECT, 0, 0, -One, 0, 0, 1, 1, 0, 540);
    add_row(OP_PROJECT, 0, 0, 0, One, 0, 1, 1, 960, 0);
    add_row(OP_PROJECT, 0, 0, 0, -One, 0, 1, 1, 960, 1080);
    add_row(OP_PROJECT, 0, 0, One + 1, 0, 0, 1, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, 0, -One - 1, 0, 1, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
    add_row(OP_LOAD, 10, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 14, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, One / 3, -One / 5, 3, 0, 0, 0, 0);
    // row w goes to zero, column w carries the point
    add_row(OP_LOAD, 14, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 15, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 7, One, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, One / 2, One, 0, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, One / 2, -One / 2, 0, 0, 0, 0, 0);
    // w right at the threshold, and one below it
    add_row(OP_LOAD, 7, WMin, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 5, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, 0, One, 0, 0, 0, 0, 0);
    add_row(OP_LOAD, 7, WMin - 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_PROJECT, 0, 0, 0, One, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                directed_rows[i].typed, directed_rows[i].want);
    end
    // pause the sender until everything so far is out
    drain();

    // zero viewport, 8192 square, smallest, random, wide with stray high bits, default
    cfg_w = '{0, 8192, 1, 0, 0, 1920};
    cfg_h = '{0, 8192, 1, 0, 0, 1080};
    cfg_w[3] = $urandom_range(1, 8192);
    cfg_h[3] = $urandom_range(1, 8192);
    cfg_w[4] = 16383;
    cfg_h[4] = $urandom_range(1, 16383);
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_WIDTH, (p == 4) ? ($urandom & 32'hffffc000) | cfg_w[p] : cfg_w[p]);
      write_reg(REG_HEIGHT, (p == 4) ? ($urandom & 32'hffffc000) | cfg_h[p] : cfg_h[p]);
      if (p == 5) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      random_phase(205);
      drain();
    end

    if (errors == 0) begin
      $display("perspective_point_projector verification clean");
    end else begin
      $display("perspective_point_projector verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #20000000;
    $display("perspective_point_projector verification failed");
    $finish;
  end

endmodule

### files.f
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_xform.sv
rtl/ppp_div.sv
rtl/perspective_point_projector.sv
rtl/ppp_checker.sv
test/testbench.sv
